// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Check a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`endif

// File: design/mstq_pkg.sv
// ----------------------------------------------------------------------------
// mstq_pkg
// Types, sizes and codes of the two-class multi-server queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mstq_pkg;

  localparam int NUM_SERVERS = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_QUEUES  = 2 * NUM_SERVERS;

  localparam int SRV_W   = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int SCNT_W  = $clog2(NUM_SERVERS + 1);
  localparam int SUM_W   = SCNT_W + 1;
  localparam int QIDX_W  = SRV_W + 1;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_AW  = QIDX_W + PTR_W;
  localparam int RAM_DEPTH = NUM_QUEUES * (2 ** PTR_W);

  localparam int CID_W   = 16;
  localparam int SIDX_W  = 2;
  localparam int QUOTA_W = 8;
  localparam int SIU_W   = 3;
  localparam int NUM_QUOTA_REGS = 4;

  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;

  typedef enum logic [2:0] {
    REG_SERVERS_IN_USE = 3'd0,
    REG_QUOTA0         = 3'd1,
    REG_QUOTA1         = 3'd2,
    REG_QUOTA2         = 3'd3,
    REG_QUOTA3         = 3'd4
  } reg_idx_e;

  typedef enum logic {
    MODE_ENQ   = 1'b0,
    MODE_SERVE = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ST_ENQUEUED = 3'd0,
    ST_FULL     = 3'd1,
    ST_UNKNOWN  = 3'd2,
    ST_SERVED   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef struct packed {
    logic             mode;
    logic [SIDX_W-1:0] server_index;
    logic             priority_req;
    logic [CID_W-1:0] client_id;
  } in_word_t;

  typedef struct packed {
    status_e          status;
    logic [CID_W-1:0] served_client;
    logic [SIDX_W-1:0] served_server;
    logic             served_priority;
    logic             end_of_turn;
  } out_word_t;

  // Result of the server search for one serve word.
  typedef struct packed {
    logic               found;
    logic [SRV_W-1:0]   server;
    logic [QUOTA_W-1:0] served_before;
  } pick_t;

  function automatic logic [PTR_W-1:0] wrap_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (int'(p) + 1 >= QUEUE_DEPTH) r = '0;
    else                            r = p + 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/multi_server_two_class_queue_core.sv
// ----------------------------------------------------------------------------
// multi_server_two_class_queue_core
// Per-server high and normal FIFOs of client ids in one RAM, served in
// round-robin turns with per-server quota, high class first.
// The result word is staged in a pending register and then moved to the
// output register; a served word takes its client id from the RAM then.
// No new word is taken while a result is staged; the serve path waits on the
// queue RAM's registered read, and a full output register stalls the input.
// Reset: pointers, counts, turn cursor and handshake clear at once; RAM
// contents are left as they are, only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_server_two_class_queue_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  mstq_pkg::in_word_t           in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output mstq_pkg::out_word_t          out_word_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mstq_pkg::APB_AW-1:0]  paddr,
  input  logic [mstq_pkg::APB_DW-1:0]  pwdata,
  output logic [mstq_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  import mstq_pkg::*;

  // configuration
  logic [SIU_W-1:0]   siu_q;
  logic [QUOTA_W-1:0] quota_q [NUM_SERVERS];
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  // queue bookkeeping
  logic [CNT_W-1:0] cnt_q  [NUM_QUEUES];
  logic [CNT_W-1:0] cnt_d  [NUM_QUEUES];
  logic [PTR_W-1:0] head_q [NUM_QUEUES];
  logic [PTR_W-1:0] head_d [NUM_QUEUES];
  logic [PTR_W-1:0] tail_q [NUM_QUEUES];
  logic [PTR_W-1:0] tail_d [NUM_QUEUES];
  logic [SRV_W-1:0]   turn_server_q, turn_server_d;
  logic [QUOTA_W-1:0] turn_served_q, turn_served_d;

  // result staging
  logic      pend_valid_q, pend_valid_d;
  logic      pend_ram_q, pend_ram_d;
  out_word_t pend_q, pend_d;
  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;

  // datapath
  logic [SCNT_W-1:0]      n_active;
  logic [NUM_SERVERS-1:0] nonempty;
  pick_t                  pick;
  logic                   in_fire, move;
  logic [QIDX_W-1:0]      qe, qs, qn;
  logic                   use_high;
  logic [CNT_W-1:0]       cnt_pop, cnt_other;
  logic [QUOTA_W-1:0]     done_new;
  logic                   end_turn;
  logic [SRV_W-1:0]       next_srv;
  logic                   ram_we, ram_re;
  logic [RAM_AW-1:0]      ram_waddr, ram_raddr;
  logic [CID_W-1:0]       ram_rdata;

  // --------------------------------------------------------------------------
  // APB register file
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      siu_q <= SIU_W'(NUM_QUOTA_REGS);
      for (int s = 0; s < NUM_SERVERS; s++) quota_q[s] <= QUOTA_W'(1);
    end else if (cfg_wr) begin
      if (cfg_idx == REG_SERVERS_IN_USE) siu_q <= pwdata[SIU_W-1:0];
      for (int s = 0; s < NUM_SERVERS; s++) begin
        if ((s < NUM_QUOTA_REGS) && (int'(cfg_idx) == int'(REG_QUOTA0) + s)) begin
          quota_q[s] <= pwdata[QUOTA_W-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx == REG_SERVERS_IN_USE) prdata = APB_DW'(siu_q);
    for (int s = 0; s < NUM_SERVERS; s++) begin
      if ((s < NUM_QUOTA_REGS) && (int'(cfg_idx) == int'(REG_QUOTA0) + s)) begin
        prdata = APB_DW'(quota_q[s]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Server selection
  // --------------------------------------------------------------------------
  always_comb begin
    if (int'(siu_q) >= NUM_SERVERS) n_active = SCNT_W'(NUM_SERVERS);
    else                            n_active = SCNT_W'(siu_q);
    for (int s = 0; s < NUM_SERVERS; s++) begin
      nonempty[s] = (cnt_q[2*s] != '0) || (cnt_q[2*s+1] != '0);
    end
  end

  mstq_pick u_pick (
    .n_active_i    (n_active),
    .nonempty_i    (nonempty),
    .quota_i       (quota_q),
    .turn_server_i (turn_server_q),
    .turn_served_i (turn_served_q),
    .pick_o        (pick)
  );

  // --------------------------------------------------------------------------
  // Queue RAM
  // --------------------------------------------------------------------------
  mstq_ram #(
    .WIDTH (CID_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_word_i.client_id),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Item processing
  // --------------------------------------------------------------------------
  assign in_ready_o = !pend_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign move       = pend_valid_q && (!out_valid_q || out_ready_i);

  always_comb begin
    qe        = QIDX_W'(2 * int'(in_word_i.server_index) + int'(in_word_i.priority_req));
    qn        = QIDX_W'(2 * int'(pick.server));
    use_high  = cnt_q[qn + 1'b1] != '0;
    qs        = use_high ? qn + 1'b1 : qn;
    cnt_pop   = cnt_q[qs] - 1'b1;
    cnt_other = use_high ? cnt_q[qn] : '0;
    done_new  = pick.served_before + 1'b1;
    end_turn  = (done_new >= quota_q[pick.server]) ||
                ((cnt_pop == '0) && (cnt_other == '0));
    if (SUM_W'(pick.server) + SUM_W'(1) >= SUM_W'(n_active)) next_srv = '0;
    else                                                     next_srv = pick.server + 1'b1;
    ram_waddr = {qe, tail_q[qe]};
    ram_raddr = {qs, head_q[qs]};
  end

  always_comb begin
    cnt_d         = cnt_q;
    head_d        = head_q;
    tail_d        = tail_q;
    turn_server_d = turn_server_q;
    turn_served_d = turn_served_q;
    pend_valid_d  = pend_valid_q;
    pend_ram_d    = pend_ram_q;
    pend_d        = pend_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    // advance the staged result, taking the client id from the RAM for a served word
    if (move) begin
      out_valid_d  = 1'b1;
      out_d        = pend_q;
      if (pend_ram_q) out_d.served_client = ram_rdata;
      pend_valid_d = 1'b0;
    end

    if (in_fire) begin
      pend_valid_d = 1'b1;
      pend_ram_d   = 1'b0;
      pend_d       = '0;
      if (in_word_i.mode == MODE_ENQ) begin
        if (SUM_W'(in_word_i.server_index) >= SUM_W'(n_active)) begin
          pend_d.status = ST_UNKNOWN;
        end else if (int'(cnt_q[qe]) >= QUEUE_DEPTH) begin
          pend_d.status = ST_FULL;
        end else begin
          ram_we        = 1'b1;
          tail_d[qe]    = wrap_ptr(tail_q[qe]);
          cnt_d[qe]     = cnt_q[qe] + 1'b1;
          pend_d.status = ST_ENQUEUED;
        end
      end else if (pick.found) begin
        ram_re                 = 1'b1;
        pend_ram_d             = 1'b1;
        head_d[qs]             = wrap_ptr(head_q[qs]);
        cnt_d[qs]              = cnt_pop;
        pend_d.status          = ST_SERVED;
        pend_d.served_server   = SIDX_W'(pick.server);
        pend_d.served_priority = use_high;
        pend_d.end_of_turn     = end_turn;
        if (end_turn) begin
          turn_server_d = next_srv;
          turn_served_d = '0;
        end else begin
          turn_server_d = pick.server;
          turn_served_d = done_new;
        end
      end else begin
        // nothing waiting: rewind the cursor
        pend_d.status = ST_EMPTY;
        turn_server_d = '0;
        turn_served_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        cnt_q[q]  <= '0;
        head_q[q] <= '0;
        tail_q[q] <= '0;
      end
      turn_server_q <= '0;
      turn_served_q <= '0;
      pend_valid_q  <= 1'b0;
      pend_ram_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      cnt_q         <= cnt_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      turn_server_q <= turn_server_d;
      turn_served_q <= turn_served_d;
      pend_valid_q  <= pend_valid_d;
      pend_ram_q    <= pend_ram_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "assert_macros.svh"

  `ASSERT_CLK(a_pend_drains, move |=> !pend_valid_q)
  `ASSERT_CLK(a_pend_from_accept, $rose(pend_valid_q) |-> $past(in_valid_i && in_ready_o))
  `ASSERT_CLK(a_zero_client_unless_served,
              out_valid_o && (out_word_o.status != ST_SERVED) |-> out_word_o.served_client == '0)
  `ASSERT_ALWAYS(a_no_ram_read_and_write, !(ram_we && ram_re))

endmodule

`default_nettype wire

// File: design/mstq_ram.sv
// ----------------------------------------------------------------------------
// mstq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mstq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/mstq_pick.sv
// ----------------------------------------------------------------------------
// mstq_pick
// Round-robin server search: picks the server that serves the next client.
// ----------------------------------------------------------------------------
`default_nettype none

module mstq_pick (
  input  logic [mstq_pkg::SCNT_W-1:0]  n_active_i,
  input  logic [mstq_pkg::NUM_SERVERS-1:0] nonempty_i,
  input  logic [mstq_pkg::QUOTA_W-1:0] quota_i [mstq_pkg::NUM_SERVERS],
  input  logic [mstq_pkg::SRV_W-1:0]   turn_server_i,
  input  logic [mstq_pkg::QUOTA_W-1:0] turn_served_i,
  output mstq_pkg::pick_t              pick_o
);

  import mstq_pkg::*;

  logic [NUM_SERVERS-1:0] elig;
  logic [SRV_W-1:0]       ts;
  logic [QUOTA_W-1:0]     done0;
  logic [SUM_W-1:0]       idx;

  always_comb begin
    for (int s = 0; s < NUM_SERVERS; s++) begin
      elig[s] = nonempty_i[s] && (quota_i[s] != '0) &&
                (SUM_W'(s) < SUM_W'(n_active_i));
    end
  end

  always_comb begin
    // restart the turn at server 0 when the cursor left the rotation
    if (SUM_W'(turn_server_i) >= SUM_W'(n_active_i)) begin
      ts    = '0;
      done0 = '0;
    end else begin
      ts    = turn_server_i;
      done0 = turn_served_i;
    end

    pick_o = '0;
    idx    = '0;
    if (elig[ts] && (done0 < quota_i[ts])) begin
      pick_o.found         = 1'b1;
      pick_o.server        = ts;
      pick_o.served_before = done0;
    end else begin
      // scan the following servers, the current one last with a fresh turn
      for (int k = 1; k <= NUM_SERVERS; k++) begin
        idx = SUM_W'(ts) + SUM_W'(k);
        if (idx >= SUM_W'(n_active_i)) idx = idx - SUM_W'(n_active_i);
        if (!pick_o.found && (SUM_W'(k) <= SUM_W'(n_active_i)) &&
            elig[idx[SRV_W-1:0]]) begin
          pick_o.found         = 1'b1;
          pick_o.server        = idx[SRV_W-1:0];
          pick_o.served_before = '0;
        end
      end
    end
  end

endmodule

`default_nettype wire
